>>> sv/mef_pkg.sv
`default_nettype none

package mef_pkg;

  localparam int CNT_W = 13;
  localparam int SPD_W = 16;
  localparam int TRQ_W = 16;
  localparam int TMP_W = 8;
  localparam int RATIO_W = 8;
  localparam int LIMIT_W = 31;
  localparam int ANGLE_W = 15;
  localparam int TOTAL_W = 32;
  localparam int SUM_W = TOTAL_W + 1;

  localparam int ENC_COUNTS_DEF = 8192;

  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 31;

  localparam logic [CFG_IDX_W-1:0] REG_GEAR_RATIO = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_CLEAR_LIMIT = 1'b1;

  localparam logic [RATIO_W-1:0] RATIO_RESET = 8'd1;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 31'd1000000000;

  localparam int DIV_W = 31;
  localparam int STEP_W = 5;
  localparam logic [STEP_W-1:0] SPD_STEPS = 5'd16;
  localparam logic [STEP_W-1:0] MOD_STEPS = 5'd31;
  localparam logic [STEP_W-1:0] ANG_STEPS = 5'd15;

  localparam logic [31:0] TWO_PIQ29 = 32'd3373259426;
  localparam logic [ANGLE_W-1:0] PI_Q12 = 15'd12868;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIFF,
    ST_PICK,
    ST_ADD,
    ST_CLEAR,
    ST_SPD_GO,
    ST_SPD_RUN,
    ST_MOD_GO,
    ST_MOD_RUN,
    ST_RES,
    ST_MUL,
    ST_ANG_GO,
    ST_ANG_RUN,
    ST_PUT
  } mef_state_t;

  typedef enum logic [1:0] {
    DIV_SPD,
    DIV_MOD,
    DIV_ANG
  } div_sel_t;

  typedef struct packed {
    logic     load;
    logic     diff;
    logic     pick;
    logic     add;
    logic     clear;
    logic     div_start;
    div_sel_t div_sel;
    logic     spd_cap;
    logic     res;
    logic     mul;
    logic     out_load;
  } mef_cmd_t;

  typedef struct packed {
    logic div_done;
  } mef_status_t;

endpackage

`default_nettype wire

>>> sv/mef_div.sv
`default_nettype none

module mef_div #(
  parameter int MW = 22
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [mef_pkg::DIV_W-1:0]   dividend,
  input  wire logic [MW-1:0]               rem_init,
  input  wire logic [MW-1:0]               divisor,
  input  wire logic [mef_pkg::STEP_W-1:0]  steps,
  output      logic [mef_pkg::DIV_W-1:0]   quo,
  output      logic [MW-1:0]               rem,
  output      logic                        done
);
  import mef_pkg::*;

  logic [DIV_W-1:0]  dvd;
  logic [MW-1:0]     dsr;
  logic [STEP_W-1:0] cnt;
  logic [MW:0]       trial;
  logic [MW:0]       diff;
  logic              ge;

  always_comb begin
    trial = {rem, dvd[DIV_W-1]};
    diff = trial - {1'b0, dsr};
    ge = (trial >= {1'b0, dsr});
  end

  assign done = (cnt == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= steps;
    end else if (cnt != '0) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      rem <= rem_init;
      dsr <= divisor;
      quo <= '0;
    end else if (cnt != '0) begin
      dvd <= {dvd[DIV_W-2:0], 1'b0};
      rem <= ge ? diff[MW-1:0] : trial[MW-1:0];
      quo <= {quo[DIV_W-2:0], ge};
    end
  end

endmodule

`default_nettype wire

>>> sv/mef_dp.sv
`default_nettype none

module mef_dp #(
  parameter int ENCODER_COUNTS = mef_pkg::ENC_COUNTS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire mef_pkg::mef_cmd_t                 cmd,
  output      mef_pkg::mef_status_t              status,
  input  wire logic                              cfg_write,
  input  wire logic [mef_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [mef_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  wire logic [mef_pkg::CNT_W-1:0]         rotor_count,
  input  wire logic signed [mef_pkg::SPD_W-1:0]  rotor_speed,
  input  wire logic signed [mef_pkg::TRQ_W-1:0]  torque_word,
  input  wire logic [mef_pkg::TMP_W-1:0]         temp_byte,
  output      logic signed [mef_pkg::SPD_W-1:0]  shaft_speed,
  output      logic signed [mef_pkg::ANGLE_W-1:0] shaft_angle,
  output      logic signed [mef_pkg::TOTAL_W-1:0] turn_total,
  output      logic signed [mef_pkg::TRQ_W-1:0]  torque_out,
  output      logic [mef_pkg::TMP_W-1:0]         temp_out
);
  import mef_pkg::*;

  localparam int NW = $clog2(ENCODER_COUNTS + 1);
  localparam int MW = NW + RATIO_W;
  localparam int DW = ((NW > CNT_W) ? NW : CNT_W) + 2;
  localparam int PW = MW + 32;
  localparam logic signed [DW-1:0] N_S = DW'(ENCODER_COUNTS);
  localparam logic [MW-1:0] N_M = MW'(ENCODER_COUNTS);

  logic [RATIO_W-1:0]        ratio;
  logic [LIMIT_W-1:0]        limit;
  logic [CNT_W-1:0]          present_count;
  logic [CNT_W-1:0]          prior_count;
  logic signed [TOTAL_W-1:0] angle_sum;

  logic signed [SPD_W-1:0]   speed;
  logic signed [TRQ_W-1:0]   torque;
  logic [TMP_W-1:0]          temp;

  logic signed [DW-1:0]      fwd;
  logic signed [DW-1:0]      bwd;
  logic signed [DW-1:0]      delta;
  logic signed [SUM_W-1:0]   sum;
  logic [SPD_W-1:0]          spd_res;
  logic [MW-1:0]             p;
  logic [PW-1:0]             prod;

  logic [RATIO_W-1:0]        ratio_eff;
  logic [MW-1:0]             m_val;
  logic signed [DW-1:0]      cur_s;
  logic signed [DW-1:0]      last_s;
  logic signed [DW-1:0]      diff_s;
  logic signed [DW-1:0]      fwd_next;
  logic signed [DW-1:0]      bwd_next;
  logic [DW-1:0]             mag_f;
  logic [DW-1:0]             mag_b;
  logic [SUM_W:0]            chk;
  logic                      over;
  logic [TOTAL_W-1:0]        sum_abs;
  logic [SPD_W-1:0]          spd_abs;
  logic [PW:0]               x_full;

  logic                      div_start;
  logic [DIV_W-1:0]          div_dividend;
  logic [MW-1:0]             div_rem_init;
  logic [MW-1:0]             div_divisor;
  logic [STEP_W-1:0]         div_steps;
  logic [DIV_W-1:0]          div_quo;
  logic [MW-1:0]             div_rem;
  logic                      div_done;

  always_comb begin
    ratio_eff = (ratio == '0) ? RATIO_W'(1) : ratio;
    m_val = N_M * {{(MW-RATIO_W){1'b0}}, ratio_eff};

    cur_s = $signed(DW'(present_count));
    last_s = $signed(DW'(prior_count));
    diff_s = cur_s - last_s;
    if (cur_s < last_s) begin
      fwd_next = diff_s + N_S;
      bwd_next = diff_s;
    end else begin
      fwd_next = diff_s;
      bwd_next = diff_s - N_S;
    end

    mag_f = fwd[DW-1] ? $unsigned(-fwd) : $unsigned(fwd);
    mag_b = bwd[DW-1] ? $unsigned(-bwd) : $unsigned(bwd);

    chk = {3'b000, limit} + {sum[SUM_W-1], sum};
    over = sum[SUM_W-1] ? chk[SUM_W] : (sum[TOTAL_W-1:0] > {1'b0, limit});

    sum_abs = angle_sum[TOTAL_W-1] ? $unsigned(-angle_sum) : $unsigned(angle_sum);
    spd_abs = speed[SPD_W-1] ? $unsigned(-speed) : $unsigned(speed);

    x_full = {1'b0, prod} + {{(PW-MW-15){1'b0}}, m_val, 16'b0};
  end

  always_comb begin
    div_start = cmd.div_start;
    unique case (cmd.div_sel)
      DIV_SPD: begin
        div_dividend = {spd_abs, {(DIV_W-SPD_W){1'b0}}};
        div_rem_init = '0;
        div_divisor = {{(MW-RATIO_W){1'b0}}, ratio_eff};
        div_steps = SPD_STEPS;
      end
      DIV_MOD: begin
        div_dividend = sum_abs[DIV_W-1:0];
        div_rem_init = '0;
        div_divisor = m_val;
        div_steps = MOD_STEPS;
      end
      DIV_ANG: begin
        div_dividend = {x_full[31:17], {(DIV_W-15){1'b0}}};
        div_rem_init = x_full[MW+31:32];
        div_divisor = m_val;
        div_steps = ANG_STEPS;
      end
      default: begin
        div_dividend = '0;
        div_rem_init = '0;
        div_divisor = m_val;
        div_steps = '0;
      end
    endcase
  end

  mef_div #(
    .MW(MW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .rem_init (div_rem_init),
    .divisor  (div_divisor),
    .steps    (div_steps),
    .quo      (div_quo),
    .rem      (div_rem),
    .done     (div_done)
  );

  assign status.div_done = div_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      ratio <= RATIO_RESET;
      limit <= LIMIT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_GEAR_RATIO:  ratio <= cfg_data[RATIO_W-1:0];
        REG_CLEAR_LIMIT: limit <= cfg_data[LIMIT_W-1:0];
        default:         ratio <= ratio;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      present_count <= '0;
      prior_count <= '0;
      angle_sum <= '0;
    end else begin
      if (cmd.load) begin
        if (present_count != '0) begin
          prior_count <= present_count;
        end
        present_count <= rotor_count;
      end
      if (cmd.clear) begin
        angle_sum <= over ? '0 : $signed(sum[TOTAL_W-1:0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      speed <= rotor_speed;
      torque <= torque_word;
      temp <= temp_byte;
    end
    if (cmd.diff) begin
      fwd <= fwd_next;
      bwd <= bwd_next;
    end
    if (cmd.pick) begin
      delta <= (mag_f < mag_b) ? fwd : bwd;
    end
    if (cmd.add) begin
      sum <= {angle_sum[TOTAL_W-1], angle_sum} + {{(SUM_W-DW){delta[DW-1]}}, delta};
    end
    if (cmd.spd_cap) begin
      spd_res <= speed[SPD_W-1] ? (~div_quo[SPD_W-1:0] + 1'b1) : div_quo[SPD_W-1:0];
    end
    if (cmd.res) begin
      p <= (angle_sum[TOTAL_W-1] && (div_rem != '0)) ? (m_val - div_rem) : div_rem;
    end
    if (cmd.mul) begin
      prod <= PW'(p) * PW'(TWO_PIQ29);
    end
    if (cmd.out_load) begin
      shaft_speed <= $signed(spd_res);
      shaft_angle <= $signed(div_quo[ANGLE_W-1:0] - PI_Q12);
      turn_total <= angle_sum;
      torque_out <= torque;
      temp_out <= temp;
    end
  end

endmodule

`default_nettype wire

>>> sv/mef_ctrl.sv
`default_nettype none

module mef_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output      logic                  in_stall,
  output      logic                  out_valid,
  input  wire logic                  out_stall,
  output      mef_pkg::mef_cmd_t     cmd,
  input  wire mef_pkg::mef_status_t  status
);
  import mef_pkg::*;

  mef_state_t state;
  mef_state_t state_next;
  logic       out_valid_next;
  logic       put_go;

  assign put_go = (state == ST_PUT) && (!out_valid || !out_stall);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:    if (in_valid) state_next = ST_DIFF;
      ST_DIFF:    state_next = ST_PICK;
      ST_PICK:    state_next = ST_ADD;
      ST_ADD:     state_next = ST_CLEAR;
      ST_CLEAR:   state_next = ST_SPD_GO;
      ST_SPD_GO:  state_next = ST_SPD_RUN;
      ST_SPD_RUN: if (status.div_done) state_next = ST_MOD_GO;
      ST_MOD_GO:  state_next = ST_MOD_RUN;
      ST_MOD_RUN: if (status.div_done) state_next = ST_RES;
      ST_RES:     state_next = ST_MUL;
      ST_MUL:     state_next = ST_ANG_GO;
      ST_ANG_GO:  state_next = ST_ANG_RUN;
      ST_ANG_RUN: if (status.div_done) state_next = ST_PUT;
      ST_PUT:     if (put_go) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.div_sel = DIV_SPD;
    unique case (state)
      ST_IDLE:    cmd.load = in_valid;
      ST_DIFF:    cmd.diff = 1'b1;
      ST_PICK:    cmd.pick = 1'b1;
      ST_ADD:     cmd.add = 1'b1;
      ST_CLEAR:   cmd.clear = 1'b1;
      ST_SPD_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel = DIV_SPD;
      end
      ST_SPD_RUN: cmd.spd_cap = status.div_done;
      ST_MOD_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel = DIV_MOD;
      end
      ST_MOD_RUN: cmd.div_sel = DIV_MOD;
      ST_RES:     cmd.res = 1'b1;
      ST_MUL:     cmd.mul = 1'b1;
      ST_ANG_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel = DIV_ANG;
      end
      ST_ANG_RUN: cmd.div_sel = DIV_ANG;
      ST_PUT:     cmd.out_load = put_go;
      default:    cmd.load = 1'b0;
    endcase
  end

  always_comb begin
    in_stall = (state != ST_IDLE);
    if (put_go) begin
      out_valid_next = 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

`default_nettype wire

>>> sv/motor_encoder_feedback_tracker_unit.sv
// Multi-turn rotor angle tracker for one geared motor feedback frame per item.
// Each item updates a running rotor count total by the shorter wrapped delta
// (cleared to zero once its magnitude passes angle_clear_limit) and returns
// shaft speed (rotor speed / gear ratio, toward zero), shaft angle in signed
// Q2.12 radians from minus pi to pi, the total, and torque and temperature
// unchanged. Gear ratio zero acts as one. Registers: index 0 gear_ratio,
// index 1 angle_clear_limit; write them only while no item is in flight.
// An item's result is loaded into the output register once that register
// is free, and the next item is taken the cycle after; the work runs on
// the shared shift-subtract divider, which runs 16 steps for the speed,
// 31 for the angle residue and 15 for the radian scaling.
// The output register holds a finished result while the next item runs.
`default_nettype none

module motor_encoder_feedback_tracker_unit #(
  parameter int ENCODER_COUNTS = mef_pkg::ENC_COUNTS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_write,
  input  wire logic [mef_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [mef_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire logic                               in_valid,
  output      logic                               in_stall,
  input  wire logic [mef_pkg::CNT_W-1:0]          rotor_count,
  input  wire logic signed [mef_pkg::SPD_W-1:0]   rotor_speed,
  input  wire logic signed [mef_pkg::TRQ_W-1:0]   torque_word,
  input  wire logic [mef_pkg::TMP_W-1:0]          temp_byte,
  output      logic                               out_valid,
  input  wire logic                               out_stall,
  output      logic signed [mef_pkg::SPD_W-1:0]   shaft_speed,
  output      logic signed [mef_pkg::ANGLE_W-1:0] shaft_angle,
  output      logic signed [mef_pkg::TOTAL_W-1:0] turn_total,
  output      logic signed [mef_pkg::TRQ_W-1:0]   torque_out,
  output      logic [mef_pkg::TMP_W-1:0]          temp_out
);
  import mef_pkg::*;

  mef_cmd_t    cmd;
  mef_status_t status;

  mef_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .status    (status)
  );

  mef_dp #(
    .ENCODER_COUNTS(ENCODER_COUNTS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .rotor_count (rotor_count),
    .rotor_speed (rotor_speed),
    .torque_word (torque_word),
    .temp_byte   (temp_byte),
    .shaft_speed (shaft_speed),
    .shaft_angle (shaft_angle),
    .turn_total  (turn_total),
    .torque_out  (torque_out),
    .temp_out    (temp_out)
  );

endmodule

`default_nettype wire

>>> dv/frame_tracker_checker.sv
module frame_tracker_checker #(
  parameter int ENCODER_COUNTS = mef_pkg::ENC_COUNTS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [mef_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mef_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                               in_valid,
  input  logic                               in_stall,
  input  logic [mef_pkg::CNT_W-1:0]          rotor_count,
  input  logic signed [mef_pkg::SPD_W-1:0]   rotor_speed,
  input  logic signed [mef_pkg::TRQ_W-1:0]   torque_word,
  input  logic [mef_pkg::TMP_W-1:0]          temp_byte,
  input  logic                               out_valid,
  input  logic                               out_stall,
  input  logic signed [mef_pkg::SPD_W-1:0]   shaft_speed,
  input  logic signed [mef_pkg::ANGLE_W-1:0] shaft_angle,
  input  logic signed [mef_pkg::TOTAL_W-1:0] turn_total,
  input  logic signed [mef_pkg::TRQ_W-1:0]   torque_out,
  input  logic [mef_pkg::TMP_W-1:0]          temp_out,
  output int                                 fail_count,
  output int                                 frames_due
);
  import mef_pkg::*;

  localparam longint unsigned PI_Q29 = 64'd1686629713;
  localparam longint HALF_TURN_Q12 = 12868;

  typedef struct {
    logic signed [SPD_W-1:0]   speed;
    logic signed [ANGLE_W-1:0] angle;
    logic signed [TOTAL_W-1:0] total;
    logic signed [TRQ_W-1:0]   torque;
    logic [TMP_W-1:0]          temp;
  } shaft_frame_t;

  shaft_frame_t frames_owed[$];

  logic [RATIO_W-1:0]        ratio_reg;
  logic [LIMIT_W-1:0]        limit_reg;
  logic [CNT_W-1:0]          count_now;
  logic [CNT_W-1:0]          count_prev;
  logic signed [TOTAL_W-1:0] rotor_total;

  initial begin
    fail_count = 0;
    frames_due = 0;
  end

  function automatic shaft_frame_t track_frame(input logic [CNT_W-1:0] cnt,
                                               input logic signed [SPD_W-1:0] spd,
                                               input logic signed [TRQ_W-1:0] trq,
                                               input logic [TMP_W-1:0] tmp);
    longint ratio, cur, last, fwd, bwd, fwd_mag, bwd_mag, sum, sum_mag, span, resid;
    longint turns;
    longint unsigned num, den;
    shaft_frame_t r;
    ratio = (ratio_reg == 0) ? 1 : longint'(ratio_reg);
    if (count_now != 0) count_prev = count_now;
    count_now = cnt;
    cur = longint'(count_now);
    last = longint'(count_prev);
    if (cur < last) begin
      fwd = cur + ENCODER_COUNTS - last;
      bwd = cur - last;
    end else begin
      fwd = cur - last;
      bwd = cur - ENCODER_COUNTS - last;
    end
    fwd_mag = (fwd < 0) ? -fwd : fwd;
    bwd_mag = (bwd < 0) ? -bwd : bwd;
    sum = longint'(rotor_total) + ((fwd_mag < bwd_mag) ? fwd : bwd);
    sum_mag = (sum < 0) ? -sum : sum;
    if (sum_mag > longint'(limit_reg)) sum = 0;
    rotor_total = sum[TOTAL_W-1:0];
    span = ENCODER_COUNTS * ratio;
    resid = sum % span;
    if (resid < 0) resid = resid + span;
    num = resid;
    num = num * 2 * PI_Q29;
    den = span;
    den = den << 17;
    turns = (num + (den >> 1)) / den;
    r.speed = SPD_W'(longint'(spd) / ratio);
    r.angle = ANGLE_W'(turns - HALF_TURN_Q12);
    r.total = rotor_total;
    r.torque = trq;
    r.temp = tmp;
    return r;
  endfunction

  task automatic check_field(input string field, input longint want_v, input longint got_v);
    if (want_v != got_v) begin
      fail_count = fail_count + 1;
      $display("%0t %s: expected %0d, actual %0d", $time, field, want_v, got_v);
    end
  endtask

  always @(posedge clk) begin : watch
    shaft_frame_t want;
    if (rst) begin
      ratio_reg = RATIO_RESET;
      limit_reg = LIMIT_RESET;
      count_now = '0;
      count_prev = '0;
      rotor_total = '0;
      frames_owed.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_GEAR_RATIO:  ratio_reg = cfg_data[RATIO_W-1:0];
          REG_CLEAR_LIMIT: limit_reg = cfg_data[LIMIT_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (frames_owed.size() == 0) begin
          fail_count = fail_count + 1;
          $display("%0t unexpected item: expected none, actual turn_total %0d",
                   $time, turn_total);
        end else begin
          want = frames_owed.pop_front();
          check_field("shaft_speed", want.speed, shaft_speed);
          check_field("shaft_angle", want.angle, shaft_angle);
          check_field("turn_total", want.total, turn_total);
          check_field("torque_out", want.torque, torque_out);
          check_field("temp_out", want.temp, temp_out);
        end
      end
      if (in_valid && !in_stall)
        frames_owed.push_back(track_frame(rotor_count, rotor_speed, torque_word, temp_byte));
    end
    frames_due = frames_owed.size();
  end

endmodule

>>> dv/motor_encoder_feedback_tracker_unit_tb.sv
module motor_encoder_feedback_tracker_unit_tb;
  import mef_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int PHASE_ITEMS = 172;

  logic clk;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [CNT_W-1:0] rotor_count = '0;
  logic signed [SPD_W-1:0] rotor_speed = '0;
  logic signed [TRQ_W-1:0] torque_word = '0;
  logic [TMP_W-1:0] temp_byte = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [SPD_W-1:0] shaft_speed;
  logic signed [ANGLE_W-1:0] shaft_angle;
  logic signed [TOTAL_W-1:0] turn_total;
  logic signed [TRQ_W-1:0] torque_out;
  logic [TMP_W-1:0] temp_out;

  int fail_count;
  int frames_due;
  int cycles = 0;
  int calm_left = 0;
  int heading_left = 0;
  int heading = 1;
  logic [CNT_W-1:0] walk_count = '0;

  motor_encoder_feedback_tracker_unit u_dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .rotor_count(rotor_count), .rotor_speed(rotor_speed),
    .torque_word(torque_word), .temp_byte(temp_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .shaft_speed(shaft_speed), .shaft_angle(shaft_angle), .turn_total(turn_total),
    .torque_out(torque_out), .temp_out(temp_out)
  );

  frame_tracker_checker u_check (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .rotor_count(rotor_count), .rotor_speed(rotor_speed),
    .torque_word(torque_word), .temp_byte(temp_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .shaft_speed(shaft_speed), .shaft_angle(shaft_angle), .turn_total(turn_total),
    .torque_out(torque_out), .temp_out(temp_out),
    .fail_count(fail_count), .frames_due(frames_due)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("motor_encoder_feedback_tracker_unit regression: fail");
      $finish;
    end
  end

  initial begin : result_backpressure
    int r;
    int len;
    @(posedge clk);
    forever begin
      r = $urandom_range(0, 99);
      if (r < 12) begin
        out_stall <= 1'b1;
        len = $urandom_range(20, 100);
      end else if (r < 50) begin
        out_stall <= 1'b1;
        len = $urandom_range(1, 3);
      end else if (r < 90) begin
        out_stall <= 1'b0;
        len = $urandom_range(1, 10);
      end else begin
        out_stall <= 1'b0;
        len = $urandom_range(200, 600);
      end
      repeat (len) @(posedge clk);
    end
  end

  function automatic int pick_gap();
    int r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      calm_left = $urandom_range(20, 60);
      return 0;
    end
    if (r < 40) return 0;
    if (r < 70) return $urandom_range(1, 20);
    if (r < 92) return $urandom_range(20, 80);
    return $urandom_range(80, 140);
  endfunction

  task automatic send_frame(input logic [CNT_W-1:0] cnt, input logic [SPD_W-1:0] spd,
                            input logic [TRQ_W-1:0] trq, input logic [TMP_W-1:0] tmp);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    rotor_count <= cnt;
    rotor_speed <= spd;
    torque_word <= trq;
    temp_byte <= tmp;
    walk_count = cnt;
    do @(negedge clk); while (in_stall);
    @(posedge clk);
  endtask

  // hold off until every pending result has drained
  task automatic await_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (frames_due != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_tracker(input logic [RATIO_W-1:0] ratio,
                                 input logic [LIMIT_W-1:0] limit);
    cfg_write <= 1'b1;
    cfg_index <= REG_GEAR_RATIO;
    cfg_data <= CFG_DATA_W'(ratio);
    @(posedge clk);
    cfg_index <= REG_CLEAR_LIMIT;
    cfg_data <= CFG_DATA_W'(limit);
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic random_frame();
    int r;
    logic [CNT_W-1:0] cnt;
    logic [SPD_W-1:0] spd;
    if (heading_left == 0) begin
      heading = ($urandom_range(0, 1) == 1) ? 1 : -1;
      heading_left = $urandom_range(5, 40);
    end
    heading_left--;
    r = $urandom_range(0, 99);
    if (r < 70)
      cnt = walk_count + CNT_W'(heading * int'($urandom_range(0, 4095)));
    else if (r < 82)
      cnt = walk_count + CNT_W'(heading * int'($urandom_range(0, 40)));
    else if (r < 91)
      cnt = CNT_W'($urandom_range(0, 8191));
    else if (r < 96)
      cnt = '0;
    else
      cnt = walk_count + 13'd4096;
    r = $urandom_range(0, 9);
    if (r == 0) spd = 16'h8000;
    else if (r == 1) spd = 16'h7fff;
    else spd = SPD_W'($urandom_range(0, 65535));
    send_frame(cnt, spd, TRQ_W'($urandom_range(0, 65535)), TMP_W'($urandom_range(0, 255)));
  endtask

  task automatic run_phase(input logic [RATIO_W-1:0] ratio, input logic [LIMIT_W-1:0] limit);
    await_results();
    program_tracker(ratio, limit);
    repeat (PHASE_ITEMS) begin
      random_frame();
      if ($urandom_range(0, 149) == 0) await_results();
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    send_frame(13'd0, 16'd0, 16'd0, 8'd0);
    send_frame(13'd8191, 16'h7fff, 16'h7fff, 8'd255);
    send_frame(13'd0, 16'h8000, 16'h8000, 8'd0);
    send_frame(13'd4096, 16'hffff, 16'hffff, 8'd128);
    send_frame(13'd0, 16'd1, 16'd1, 8'd1);
    send_frame(13'd1, 16'd7, 16'h5555, 8'h55);
    send_frame(13'd4097, 16'hfff9, 16'haaaa, 8'haa);
    send_frame(13'd3000, 16'd100, 16'd0, 8'd20);
    send_frame(13'd1500, 16'd200, 16'd0, 8'd21);
    send_frame(13'd10, 16'd300, 16'd0, 8'd22);
    send_frame(13'd7000, 16'd400, 16'd0, 8'd23);
    send_frame(13'd5000, 16'd500, 16'd0, 8'd24);

    await_results();
    program_tracker(8'd0, 31'd0);
    send_frame(13'd100, 16'h8000, 16'd9, 8'd9);
    send_frame(13'd50, 16'h7fff, 16'd9, 8'd9);
    send_frame(13'd50, 16'hfffe, 16'd9, 8'd9);
    send_frame(13'd0, 16'd3, 16'd9, 8'd9);

    await_results();
    program_tracker(8'd255, 31'h7fffffff);
    send_frame(13'd2000, 16'h8000, 16'd1, 8'd2);
    send_frame(13'd6000, 16'h7fff, 16'd1, 8'd2);
    send_frame(13'd1000, 16'hff02, 16'd1, 8'd2);
    send_frame(13'd5000, 16'd254, 16'd1, 8'd2);
    send_frame(13'd8191, 16'd255, 16'd1, 8'd2);
    send_frame(13'd3, 16'hff01, 16'd1, 8'd2);

    run_phase(8'd2, 31'h7fffffff);
    run_phase(8'd255, 31'd60000);
    run_phase(8'd0, 31'd300000);
    run_phase(8'd1, 31'd9000);
    run_phase(8'd37, 31'h7fffffff);
    run_phase(8'd128, 31'd1500000);
    run_phase(8'd1, 31'd1000000000);
    run_phase(8'd13, 31'd25000);
    run_phase(8'd255, 31'h7fffffff);

    in_valid <= 1'b0;
    do @(negedge clk); while (frames_due != 0);
    repeat (100) @(posedge clk);
    if (fail_count == 0)
      $display("motor_encoder_feedback_tracker_unit regression: pass");
    else
      $display("motor_encoder_feedback_tracker_unit regression: fail");
    $finish;
  end

endmodule
